@@ sv/s2a_pkg.sv @@
// Shared item types, scancode constants and the set-1 to ASCII table.
package s2a_pkg;

  typedef struct packed {
    logic       opcode;
    logic [7:0] scancode;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic       empty_res;
  } out_item_t;

  localparam logic       OP_KEY          = 1'b0;
  localparam logic       OP_READ         = 1'b1;

  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [7:0] SC_TABLE_LAST   = 8'd57;
  localparam logic [5:0] SC_SEVEN        = 6'd8;
  localparam logic [5:0] SC_BACKSLASH    = 6'd43;

  localparam logic [6:0] CH_NONE         = 7'h00;
  localparam logic [6:0] CH_AMPERSAND    = 7'h26;
  localparam logic [6:0] CH_PIPE         = 7'h7C;

  // Unshifted set-1 translation; zero means the code makes no character.
  function automatic logic [6:0] ascii_lookup(input logic [5:0] code);
    logic [6:0] ch;
    case (code)
      6'd1:    ch = 7'h1B;
      6'd2:    ch = 7'h31;
      6'd3:    ch = 7'h32;
      6'd4:    ch = 7'h33;
      6'd5:    ch = 7'h34;
      6'd6:    ch = 7'h35;
      6'd7:    ch = 7'h36;
      6'd8:    ch = 7'h37;
      6'd9:    ch = 7'h38;
      6'd10:   ch = 7'h39;
      6'd11:   ch = 7'h30;
      6'd12:   ch = 7'h2D;
      6'd13:   ch = 7'h3D;
      6'd14:   ch = 7'h7F;
      6'd15:   ch = 7'h09;
      6'd16:   ch = 7'h71;
      6'd17:   ch = 7'h77;
      6'd18:   ch = 7'h65;
      6'd19:   ch = 7'h72;
      6'd20:   ch = 7'h74;
      6'd21:   ch = 7'h79;
      6'd22:   ch = 7'h75;
      6'd23:   ch = 7'h69;
      6'd24:   ch = 7'h6F;
      6'd25:   ch = 7'h70;
      6'd26:   ch = 7'h5B;
      6'd27:   ch = 7'h5D;
      6'd28:   ch = 7'h0A;
      6'd30:   ch = 7'h61;
      6'd31:   ch = 7'h73;
      6'd32:   ch = 7'h64;
      6'd33:   ch = 7'h66;
      6'd34:   ch = 7'h67;
      6'd35:   ch = 7'h68;
      6'd36:   ch = 7'h6A;
      6'd37:   ch = 7'h6B;
      6'd38:   ch = 7'h6C;
      6'd39:   ch = 7'h3B;
      6'd40:   ch = 7'h27;
      6'd41:   ch = 7'h60;
      6'd43:   ch = 7'h5C;
      6'd44:   ch = 7'h7A;
      6'd45:   ch = 7'h78;
      6'd46:   ch = 7'h63;
      6'd47:   ch = 7'h76;
      6'd48:   ch = 7'h62;
      6'd49:   ch = 7'h6E;
      6'd50:   ch = 7'h6D;
      6'd51:   ch = 7'h2C;
      6'd52:   ch = 7'h2E;
      6'd53:   ch = 7'h2F;
      6'd57:   ch = 7'h20;
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

@@ sv/scancode_to_ascii_fifo_core.sv @@
// Keyboard front end: set-1 scancode translation into a circular character FIFO.
//
//   channel  direction  payload                 handshake
//   in_      input      s2a_pkg::in_item_t      in_valid / in_stall
//   out_     output     s2a_pkg::out_item_t     out_valid / out_stall
//
// A scancode item is done at the edge that accepts it: the shift flag, the
// table lookup and the FIFO write all happen at that edge, so scancodes stream
// at one per cycle while in_stall is low. A read item of a non-empty FIFO goes
// through the registered read port of the character memory and then into the
// output register; an empty-FIFO read fills that register at the accepting edge.
// Reset clears the shift flag, both pointers, the fill count and the output
// valid; the character memory is not cleared, since the fill count keeps
// unwritten entries from ever being read.
// in_stall is high while a memory read is in flight and while an undelivered
// result sits in the output register under out_stall.
module scancode_to_ascii_fifo_core #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  s2a_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output s2a_pkg::out_item_t out_item
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t                 state_r;
  logic                   shift_held_r;
  logic [PTR_W-1:0]       read_ptr_r;
  logic [PTR_W-1:0]       write_ptr_r;
  logic [CNT_W-1:0]       fill_count_r;
  logic                   out_valid_r;
  s2a_pkg::out_item_t     out_item_r;

  // Character memory with a registered read port.
  logic [6:0]             char_store [FIFO_DEPTH];
  logic [6:0]             mem_q_r;

  logic                   in_acc;
  logic                   is_key;
  logic                   is_read;
  logic                   fifo_empty;
  logic                   fifo_full;
  logic                   shift_held_nxt;
  logic                   out_valid_nxt;
  logic                   in_table;
  logic [6:0]             base_char;
  logic [6:0]             push_char;
  logic                   push_en;
  logic                   pop_en;
  logic [PTR_W-1:0]       read_ptr_inc;
  logic [PTR_W-1:0]       write_ptr_inc;

  // The output register must be free, or be emptied at this edge, before an
  // item is taken, so a result never has to wait for space.
  assign in_stall  = (state_r == ST_READ) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign is_key    = in_acc && (in_item.opcode == s2a_pkg::OP_KEY);
  assign is_read   = in_acc && (in_item.opcode == s2a_pkg::OP_READ);

  assign fifo_empty = (fill_count_r == '0);
  assign fifo_full  = (fill_count_r == CNT_FULL);

  assign read_ptr_inc  = (read_ptr_r == PTR_LAST) ? '0 : read_ptr_r + 1'b1;
  assign write_ptr_inc = (write_ptr_r == PTR_LAST) ? '0 : write_ptr_r + 1'b1;

  // Shift make codes set the flag and break codes clear it before the lookup.
  always_comb begin
    shift_held_nxt = shift_held_r;
    if (is_key) begin
      if ((in_item.scancode == s2a_pkg::SC_LSHIFT_MAKE) ||
          (in_item.scancode == s2a_pkg::SC_RSHIFT_MAKE)) begin
        shift_held_nxt = 1'b1;
      end
      if ((in_item.scancode == s2a_pkg::SC_LSHIFT_BREAK) ||
          (in_item.scancode == s2a_pkg::SC_RSHIFT_BREAK)) begin
        shift_held_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    in_table  = (in_item.scancode <= s2a_pkg::SC_TABLE_LAST);
    base_char = s2a_pkg::ascii_lookup(in_item.scancode[5:0]);
    push_char = base_char;
    if (shift_held_nxt) begin
      if (in_item.scancode[5:0] == s2a_pkg::SC_SEVEN) begin
        push_char = s2a_pkg::CH_AMPERSAND;
      end else if (in_item.scancode[5:0] == s2a_pkg::SC_BACKSLASH) begin
        push_char = s2a_pkg::CH_PIPE;
      end
    end
    push_en = is_key && in_table && (base_char != s2a_pkg::CH_NONE);
    pop_en  = is_read && !fifo_empty;
  end

  // A result stays while it is stalled; a finished memory read or a read of
  // the empty FIFO loads a new one.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == ST_READ) begin
      out_valid_nxt = 1'b1;
    end else if (is_read && fifo_empty) begin
      out_valid_nxt = 1'b1;
    end
  end

  // A push and a pop never share an edge, and a pop issued after a push reads
  // the array only after the write has landed, so the memory needs no forwarding.
  always_ff @(posedge clk) begin
    if (push_en) begin
      char_store[write_ptr_r] <= push_char;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_en) begin
      mem_q_r <= char_store[read_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      shift_held_r <= 1'b0;
      read_ptr_r   <= '0;
      write_ptr_r  <= '0;
      fill_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      shift_held_r <= shift_held_nxt;
      out_valid_r  <= out_valid_nxt;
      case (state_r)
        ST_IDLE: begin
          if (push_en) begin
            write_ptr_r <= write_ptr_inc;
            if (fifo_full) begin
              // Overwrite of the oldest entry: the read side moves along.
              read_ptr_r <= read_ptr_inc;
            end else begin
              fill_count_r <= fill_count_r + 1'b1;
            end
          end
          if (pop_en) begin
            read_ptr_r   <= read_ptr_inc;
            fill_count_r <= fill_count_r - 1'b1;
            state_r      <= ST_READ;
          end else if (is_read) begin
            out_item_r.char_out  <= s2a_pkg::CH_NONE;
            out_item_r.empty_res <= 1'b1;
          end
        end
        ST_READ: begin
          out_item_r.char_out  <= mem_q_r;
          out_item_r.empty_res <= 1'b0;
          state_r              <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CNT_FULL)
    else $error("fill count above FIFO depth");

  a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !out_valid_r)
    else $error("output register busy while a memory read is in flight");

  a_pop_goes_read: assert property (@(posedge clk) disable iff (!rst_n)
    pop_en |=> (state_r == ST_READ))
    else $error("pop did not start a memory read");

  a_empty_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.empty_res) |-> (out_item_r.char_out == s2a_pkg::CH_NONE))
    else $error("empty result carries a character");

  a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (is_read && fifo_empty) |=> (out_valid_r && out_item_r.empty_res && $stable(read_ptr_r)))
    else $error("read of empty FIFO mishandled");

endmodule
